// File: hw/rtl/mabs_pkg.sv
package mabs_pkg;

  localparam int CHANNELS_DEF = 6;
  localparam int BLOCKS_DEF   = 16;

  localparam int SAMPLE_W   = 12;
  localparam int QUERY_W    = 3;
  localparam int CHAN_OUT_W = 3;
  localparam int TOTAL_W    = 20;
  localparam int BSUM_W     = 16;
  // samples per block is 16, so the in-block count is 4 bits and wraps by itself
  localparam int SUB_W      = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SUM,
    ST_SUM_END,
    ST_WRITE,
    ST_TOT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sum_start;
    logic sum_rd;
    logic blk_rd;
    logic blk_wr;
    logic tot_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/mabs_ctrl.sv
module mabs_ctrl
  import mabs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = stat.first ? ST_SUM : ST_WRITE;
      end
      ST_SUM: begin
        if (stat.idx_last) state_next = ST_SUM_END;
      end
      ST_SUM_END: state_next = ST_WRITE;
      ST_WRITE:   state_next = ST_TOT_RD;
      ST_TOT_RD:  state_next = ST_OUT;
      ST_OUT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_LOOKUP: begin
        // accumulate path clears on first sample, otherwise fetch for read-modify-write
        cmd.sum_start = stat.first;
        cmd.blk_rd    = !stat.first;
      end
      ST_SUM:     cmd.sum_rd = 1'b1;
      ST_SUM_END: ;
      ST_WRITE:   cmd.blk_wr = 1'b1;
      ST_TOT_RD:  cmd.tot_rd = 1'b1;
      ST_OUT:     cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/mabs_dp.sv
module mabs_dp
  import mabs_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int BLOCKS   = BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic [QUERY_W-1:0]    query_channel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAN_OUT_W-1:0] updated_channel,
  output logic [TOTAL_W-1:0]    channel_total,
  output logic                  total_refreshed,
  output logic [TOTAL_W-1:0]    query_total
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BLK_W = $clog2(BLOCKS);
  localparam int ENTRIES = CHANNELS * BLOCKS;
  localparam int AW    = $clog2(ENTRIES);

  logic [CH_W-1:0]  pointer;
  logic [SUB_W-1:0] sub_cnt [CHANNELS];
  logic [BLK_W-1:0] blk_cnt [CHANNELS];

  logic [CH_W-1:0]     cur_ch;
  logic [BLK_W-1:0]    cur_blk;
  logic                cur_first;
  logic [SAMPLE_W-1:0] cur_sample;
  logic [CH_W-1:0]     cur_query;

  logic [BSUM_W-1:0] bmem [ENTRIES];
  logic [ENTRIES-1:0] bvalid;
  logic [BSUM_W-1:0] bdata;
  logic              bval_q;
  logic [BSUM_W-1:0] bdata_eff;

  logic [BLK_W-1:0]   idx;
  logic               pend;
  logic [BLK_W-1:0]   pend_idx;
  logic [TOTAL_W-1:0] acc;

  logic [TOTAL_W-1:0]  tmem [CHANNELS];
  logic [CHANNELS-1:0] tvalid;
  logic [TOTAL_W-1:0]  tdat_a, tdat_b;
  logic                tval_a, tval_b;

  logic [AW-1:0]     rd_addr, wr_addr;
  logic [BSUM_W-1:0] wr_data;
  logic [QUERY_W:0]  q_inc;
  logic [CH_W-1:0]   mapped;
  logic [CH_W-1:0]   ptr_next;

  assign q_inc  = {1'b0, query_channel} + (QUERY_W+1)'(1);
  assign mapped = (32'(q_inc) >= CHANNELS) ? '0 : CH_W'(q_inc);
  assign ptr_next = (32'(pointer) >= CHANNELS - 1) ? '0 : pointer + CH_W'(1);

  assign rd_addr = cmd.sum_rd ? AW'(32'(cur_ch) * BLOCKS + 32'(idx))
                              : AW'(32'(cur_ch) * BLOCKS + 32'(cur_blk));
  assign wr_addr = AW'(32'(cur_ch) * BLOCKS + 32'(cur_blk));

  // an entry never written since reset reads as zero
  assign bdata_eff = bval_q ? bdata : '0;
  assign wr_data   = cur_first ? BSUM_W'(cur_sample) : bdata_eff + BSUM_W'(cur_sample);

  assign stat.first    = cur_first;
  assign stat.idx_last = (idx == BLK_W'(BLOCKS - 1));
  assign stat.out_free = !out_valid || out_ready;

  // pointer and per-channel counters advance as the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sub_cnt[c] <= '0;
        blk_cnt[c] <= '0;
      end
    end else if (cmd.load) begin
      pointer          <= ptr_next;
      sub_cnt[pointer] <= sub_cnt[pointer] + SUB_W'(1);
      if (sub_cnt[pointer] == '1) begin
        blk_cnt[pointer] <= (32'(blk_cnt[pointer]) >= BLOCKS - 1) ? '0
                          : blk_cnt[pointer] + BLK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_ch     <= pointer;
      cur_blk    <= blk_cnt[pointer];
      cur_first  <= (sub_cnt[pointer] == '0);
      cur_sample <= sample;
      cur_query  <= mapped;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_rd || cmd.blk_rd) begin
      bdata <= bmem[rd_addr];
    end
    if (cmd.blk_wr) begin
      bmem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
      bval_q <= 1'b0;
    end else begin
      if (cmd.sum_rd || cmd.blk_rd) bval_q <= bvalid[rd_addr];
      if (cmd.blk_wr) bvalid[wr_addr] <= 1'b1;
    end
  end

  // total sweep: one accumulator read per cycle, the current block counts as cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.sum_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      idx <= '0;
      acc <= '0;
    end else begin
      if (cmd.sum_rd) begin
        idx      <= idx + BLK_W'(1);
        pend_idx <= idx;
      end
      if (pend && pend_idx != cur_blk) begin
        acc <= acc + TOTAL_W'(bdata_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_wr && cur_first) begin
      tmem[cur_ch] <= acc;
    end
    if (cmd.tot_rd) begin
      tdat_a <= tmem[cur_ch];
      tdat_b <= tmem[cur_query];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
      tval_a <= 1'b0;
      tval_b <= 1'b0;
    end else begin
      if (cmd.blk_wr && cur_first) tvalid[cur_ch] <= 1'b1;
      if (cmd.tot_rd) begin
        tval_a <= tvalid[cur_ch];
        tval_b <= tvalid[cur_query];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      updated_channel <= CHAN_OUT_W'(cur_ch);
      channel_total   <= tval_a ? tdat_a : '0;
      total_refreshed <= cur_first;
      query_total     <= tval_b ? tdat_b : '0;
    end
  end

endmodule

// File: hw/rtl/multichannel_adc_block_sum_top.sv
// Path per item: IDLE, LOOKUP, WRITE, TOT_RD, OUT on a mid-block sample; the first sample
// of a block also sweeps the block accumulator memory (SUM, SUM_END) before WRITE.
// Items are taken one at a time; the next item is taken after the result enters the
// output register, which waits in OUT while the output is stalled. A first sample is slowed
// by the one-read-per-cycle sweep over the block accumulator memory.
// Reset (rst, synchronous): pointer, counters, valid bits and totals read as zero.
module multichannel_adc_block_sum_top
  import mabs_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int BLOCKS   = BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [11:0] sample, [14:12] query_channel, [15] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] updated_channel, [22:3] channel_total, [42:23] query_total, [47:43] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] total_refreshed
  output logic                  m_axis_tuser
);

  cmd_t  cmd;
  stat_t stat;

  logic [CHAN_OUT_W-1:0] updated_channel;
  logic [TOTAL_W-1:0]    channel_total;
  logic [TOTAL_W-1:0]    query_total;

  mabs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mabs_dp #(
    .CHANNELS (CHANNELS),
    .BLOCKS   (BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .sample          (s_axis_tdata[SAMPLE_W-1:0]),
    .query_channel   (s_axis_tdata[SAMPLE_W+QUERY_W-1:SAMPLE_W]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .updated_channel (updated_channel),
    .channel_total   (channel_total),
    .total_refreshed (m_axis_tuser),
    .query_total     (query_total)
  );

  assign m_axis_tdata = {5'b0, query_total, channel_total, updated_channel};

endmodule

// File: hw/rtl/mabs_chk.sv
module mabs_chk
  import mabs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without an item in progress");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind multichannel_adc_block_sum_top mabs_chk u_mabs_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_multichannel_adc_block_sum_top.sv
`timescale 1ns / 100ps

module tb_multichannel_adc_block_sum_top;
  import mabs_pkg::*;

  localparam int CHANNELS    = CHANNELS_DEF;
  localparam int BLOCKS      = BLOCKS_DEF;
  localparam int SPB         = 16;
  localparam int COUNT_WRAP  = BLOCKS * SPB;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [CHAN_OUT_W-1:0] chan;
    logic [TOTAL_W-1:0]    total;
    logic                  refreshed;
    logic [TOTAL_W-1:0]    query_total;
  } block_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // shadow copy of the channel state
  int                  shadow_ptr;
  int                  shadow_count [CHANNELS];
  logic [BSUM_W-1:0]   shadow_acc   [CHANNELS][BLOCKS];
  logic [TOTAL_W-1:0]  shadow_total [CHANNELS];

  block_result_t pending_results[$];
  int            mismatch_count;
  int            cycle_count;
  int            stall_left;
  bit            stall_enable;

  multichannel_adc_block_sum_top #(
    .CHANNELS(CHANNELS),
    .BLOCKS  (BLOCKS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multichannel_adc_block_sum_top verification failed");
      $finish;
    end
  end

  function automatic block_result_t predict_block_sum(input logic [SAMPLE_W-1:0] smp,
                                                      input logic [QUERY_W-1:0]  qry);
    block_result_t      res;
    int                 ch;
    int                 cnt;
    int                 blk;
    bit                 first;
    int                 mapped;
    logic [TOTAL_W-1:0] acc;
    ch    = shadow_ptr;
    cnt   = shadow_count[ch];
    blk   = cnt / SPB;
    first = (cnt % SPB) == 0;
    shadow_count[ch] = (cnt + 1) % COUNT_WRAP;
    if (first) begin
      // block being started is cleared, so the total covers the other blocks only
      shadow_acc[ch][blk] = '0;
      acc = '0;
      for (int i = 0; i < BLOCKS; i++) acc = acc + TOTAL_W'(shadow_acc[ch][i]);
      shadow_total[ch] = acc;
    end
    shadow_acc[ch][blk] = shadow_acc[ch][blk] + BSUM_W'(smp);
    shadow_ptr = (ch + 1) % CHANNELS;
    mapped = int'(qry) + 1;
    if (mapped >= CHANNELS) mapped = 0;
    res.chan        = CHAN_OUT_W'(ch);
    res.total       = shadow_total[ch];
    res.refreshed   = first;
    res.query_total = shadow_total[mapped];
    return res;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [QUERY_W-1:0] qry);
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, qry, smp};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    pending_results.push_back(predict_block_sum(smp, qry));
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_enable && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    block_result_t want;
    block_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.chan        = m_axis_tdata[2:0];
      got.total       = m_axis_tdata[22:3];
      got.query_total = m_axis_tdata[42:23];
      got.refreshed   = m_axis_tuser;
      if (pending_results.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("unexpected item: chan %0d total %0d refreshed %0b query_total %0d",
                   got.chan, got.total, got.refreshed, got.query_total);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("mismatch: exp chan %0d total %0d refreshed %0b query_total %0d",
                     want.chan, want.total, want.refreshed, want.query_total);
            $display("          got chan %0d total %0d refreshed %0b query_total %0d",
                     got.chan, got.total, got.refreshed, got.query_total);
          end
        end
      end
    end
  end

  // field extremes and every query code, out-of-range ones included
  task automatic test_directed();
    logic [SAMPLE_W-1:0] pattern [4];
    pattern = '{12'h000, 12'hFFF, 12'hAAA, 12'h555};
    stall_enable = 1'b1;
    for (int i = 0; i < 24; i++) send_sample(pattern[i % 4], QUERY_W'(i % 8));
  endtask

  task automatic test_random();
    logic [SAMPLE_W-1:0] smp;
    for (int seg = 0; seg < 6; seg++) begin
      stall_enable = (seg % 3) != 2;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 7) == 0) smp = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        else smp = SAMPLE_W'($urandom_range(0, 4095));
        send_sample(smp, QUERY_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // full-scale samples back to back, no idling
  task automatic test_full_scale();
    stall_enable = 1'b0;
    for (int i = 0; i < 84; i++) send_sample(12'hFFF, QUERY_W'($urandom_range(0, 7)));
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    stall_enable   = 1'b0;
    shadow_ptr     = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      shadow_count[c] = 0;
      shadow_total[c] = '0;
      for (int b = 0; b < BLOCKS; b++) shadow_acc[c][b] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random();
    test_full_scale();

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (BLOCKS + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("multichannel_adc_block_sum_top verification clean");
    end else begin
      $display("multichannel_adc_block_sum_top verification failed");
    end
    $finish;
  end

endmodule
